>>> src/bts_pkg.sv
// Shared types and codes for the barrel thermostat sequencer.
package bts_pkg;

  localparam int unsigned TempW   = 16;
  localparam int unsigned AmountW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  localparam logic signed [TempW-1:0] LowLimitReset  = 16'sd320;   // 20.0 deg
  localparam logic signed [TempW-1:0] HighLimitReset = 16'sd1280;  // 80.0 deg

  typedef enum logic [4:0] {
    PH_WAIT         = 5'd0,
    PH_TOPUP        = 5'd1,
    PH_TOPUP_ERR    = 5'd2,
    PH_RANGE        = 5'd3,
    PH_HEATING      = 5'd4,
    PH_COOLING      = 5'd5,
    PH_PUMP_ON      = 5'd6,
    PH_PUMP_ON_ERR  = 5'd7,
    PH_HEAT_ON      = 5'd8,
    PH_HEAT_ON_ERR  = 5'd9,
    PH_COOL_ON      = 5'd10,
    PH_COOL_ON_ERR  = 5'd11,
    PH_PUMP_OFF     = 5'd12,
    PH_PUMP_OFF_ERR = 5'd13,
    PH_HEAT_OFF     = 5'd14,
    PH_HEAT_OFF_ERR = 5'd15,
    PH_COOL_OFF     = 5'd16,
    PH_COOL_OFF_ERR = 5'd17
  } phase_t;

  typedef enum logic [2:0] {
    TGT_NONE   = 3'd0,
    TGT_PUMP   = 3'd1,
    TGT_HEATER = 3'd2,
    TGT_COOLER = 3'd3,
    TGT_TOPUP  = 3'd4
  } target_t;

  typedef enum logic [2:0] {
    FLT_NONE       = 3'd0,
    FLT_TOPUP      = 3'd1,
    FLT_PUMP_ON    = 3'd2,
    FLT_HEAT_ON    = 3'd3,
    FLT_COOL_ON    = 3'd4,
    FLT_PUMP_OFF   = 3'd5,
    FLT_HEAT_OFF   = 3'd6,
    FLT_COOL_OFF   = 3'd7
  } fault_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEATER_ENABLE = 2'd0,
    REG_COOLER_ENABLE = 2'd1,
    REG_LOW_LIMIT     = 2'd2,
    REG_HIGH_LIMIT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                    heater_enable;
    logic                    cooler_enable;
    logic signed [TempW-1:0] low_limit;
    logic signed [TempW-1:0] high_limit;
  } cfg_t;

  typedef struct packed {
    logic                    temp_valid;
    logic signed [TempW-1:0] temperature;
    logic                    run_request_valid;
    logic                    run_request_value;
    logic                    topup_request_valid;
    logic [AmountW-1:0]      topup_amount;
    logic                    ack_done;
    logic                    ack_error;
  } item_t;

  typedef struct packed {
    target_t            command_target;
    logic               command_level;
    logic [AmountW-1:0] command_amount;
    phase_t             phase_code;
    fault_t             fault_code;
  } result_t;

  typedef struct packed {
    phase_t                  phase;
    phase_t                  return_phase;
    logic                    impact_is_cooler;
    logic                    running;
    logic [1:0]              run_pending;    // bit1 valid, bit0 start/stop
    logic [AmountW:0]        topup_pending;  // top bit valid
    logic [AmountW-1:0]      topup_latched;
    logic signed [TempW-1:0] last_temperature;
  } state_t;

endpackage

>>> src/barrel_thermostat_sequencer.sv
// Top level of the barrel thermostat sequencer: stream ports, tick and result registers.
//
// Each input beat is one control tick and yields exactly one result beat. A beat is
// captured in an input register, goes combinationally through one step of the phase
// sequence and lands in the result register, and a new beat is taken every cycle while
// the result side keeps up. The phase state is updated as the tick moves on to the
// result register. Configuration writes take effect in the cycle after the write beat
// and must be made while no tick is in flight. Temperatures and limits are signed 1/16
// degree values.
module barrel_thermostat_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata, from bit 0: temp_valid, temperature[15:0], run_request_valid,
  // run_request_value, topup_request_valid, topup_amount[15:0], ack_done,
  // ack_error, two zero pad bits
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bts_pkg::InDataW-1:0]         in_tdata,
  // out_tdata, from bit 0: command_target[2:0], command_level,
  // command_amount[15:0], phase_code[4:0], fault_code[2:0], four zero pad bits
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bts_pkg::OutDataW-1:0]        out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bts_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [bts_pkg::CfgDataW-1:0]        cfg_data
);

  bts_pkg::item_t   in_item_r;
  logic             in_v_r;
  bts_pkg::state_t  state_r;
  bts_pkg::state_t  state_nxt;
  bts_pkg::result_t out_r;
  bts_pkg::result_t step_res;
  logic             out_v_r;
  bts_pkg::cfg_t    cfg;
  bts_pkg::item_t   in_item;
  logic             advance;

  assign in_item.temp_valid          = in_tdata[0];
  assign in_item.temperature         = in_tdata[16:1];
  assign in_item.run_request_valid   = in_tdata[17];
  assign in_item.run_request_value   = in_tdata[18];
  assign in_item.topup_request_valid = in_tdata[19];
  assign in_item.topup_amount        = in_tdata[35:20];
  assign in_item.ack_done            = in_tdata[36];
  assign in_item.ack_error           = in_tdata[37];

  assign cfg_ready = 1'b1;

  bts_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg)
  );

  bts_step u_step (
    .state_i  (state_r),
    .cfg_i    (cfg),
    .item_i   (in_item_r),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  // tick moves to the result register when that slot is free or being drained
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r                   <= 1'b0;
      out_v_r                  <= 1'b0;
      state_r.phase            <= bts_pkg::PH_WAIT;
      state_r.return_phase     <= bts_pkg::PH_WAIT;
      state_r.impact_is_cooler <= 1'b0;
      state_r.running          <= 1'b0;
      state_r.run_pending      <= '0;
      state_r.topup_pending    <= '0;
      state_r.topup_latched    <= '0;
      state_r.last_temperature <= '0;
    end else begin
      if (in_tready)
        in_v_r <= in_tvalid;
      if (advance) begin
        state_r <= state_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid)
      in_item_r <= in_item;
    if (advance)
      out_r <= step_res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_r.fault_code, out_r.phase_code, out_r.command_amount,
                       out_r.command_level, out_r.command_target};

endmodule

>>> src/bts_cfg.sv
// Configuration register file: enables and temperature limits.
module bts_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [bts_pkg::CfgIdxW-1:0]         wr_index,
  input  logic [bts_pkg::CfgDataW-1:0]        wr_data,
  output bts_pkg::cfg_t                       cfg_o
);

  bts_pkg::cfg_t cfg_r;
  bts_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (bts_pkg::reg_idx_t'(wr_index))
        bts_pkg::REG_HEATER_ENABLE: cfg_nxt.heater_enable = wr_data[0];
        bts_pkg::REG_COOLER_ENABLE: cfg_nxt.cooler_enable = wr_data[0];
        bts_pkg::REG_LOW_LIMIT:     cfg_nxt.low_limit     = wr_data;
        bts_pkg::REG_HIGH_LIMIT:    cfg_nxt.high_limit    = wr_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heater_enable <= 1'b0;
      cfg_r.cooler_enable <= 1'b0;
      cfg_r.low_limit     <= bts_pkg::LowLimitReset;
      cfg_r.high_limit    <= bts_pkg::HighLimitReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> src/bts_step.sv
// One control tick: latch requests, step the phase sequence, form the command.
module bts_step (
  input  bts_pkg::state_t  state_i,
  input  bts_pkg::cfg_t    cfg_i,
  input  bts_pkg::item_t   item_i,
  output bts_pkg::state_t  state_o,
  output bts_pkg::result_t result_o
);

  bts_pkg::state_t  st;
  bts_pkg::result_t res;
  logic signed [bts_pkg::TempW+1:0] t2;
  logic signed [bts_pkg::TempW+1:0] mid2;
  logic run_go;
  logic has_topup;
  logic below;
  logic above;

  always_comb begin
    st = state_i;
    if (item_i.temp_valid)
      st.last_temperature = item_i.temperature;
    if (item_i.run_request_valid)
      st.run_pending = {1'b1, item_i.run_request_value};
    if (item_i.topup_request_valid)
      st.topup_pending = {1'b1, item_i.topup_amount};

    // midpoint kept exact: 2*t against low+high, one extra fraction bit
    t2   = {st.last_temperature[bts_pkg::TempW-1], st.last_temperature, 1'b0};
    mid2 = {{2{cfg_i.low_limit[bts_pkg::TempW-1]}}, cfg_i.low_limit}
         + {{2{cfg_i.high_limit[bts_pkg::TempW-1]}}, cfg_i.high_limit};
    below = st.last_temperature < cfg_i.low_limit;
    above = st.last_temperature > cfg_i.high_limit;

    // running flag as seen once the pending run request is taken
    run_go    = st.run_pending[1] ? st.run_pending[0] : st.running;
    has_topup = st.topup_pending[bts_pkg::AmountW];

    res.command_target = bts_pkg::TGT_NONE;
    res.command_level  = 1'b0;
    res.command_amount = '0;
    res.fault_code     = bts_pkg::FLT_NONE;

    unique case (st.phase)
      bts_pkg::PH_WAIT: begin
        st.running     = run_go;
        st.run_pending = '0;
        if (run_go) begin
          st.phase = bts_pkg::PH_RANGE;
        end else if (has_topup) begin
          st.topup_latched = st.topup_pending[bts_pkg::AmountW-1:0];
          st.topup_pending = '0;
          st.return_phase  = bts_pkg::PH_WAIT;
          st.phase         = bts_pkg::PH_TOPUP;
        end
      end
      bts_pkg::PH_TOPUP: begin
        res.command_target = bts_pkg::TGT_TOPUP;
        res.command_level  = 1'b1;
        res.command_amount = st.topup_latched;
        if (item_i.ack_error)     st.phase = bts_pkg::PH_TOPUP_ERR;
        else if (item_i.ack_done) st.phase = st.return_phase;
      end
      bts_pkg::PH_TOPUP_ERR: begin
        res.fault_code = bts_pkg::FLT_TOPUP;
        st.phase       = st.return_phase;
      end
      bts_pkg::PH_RANGE: begin
        st.running     = run_go;
        st.run_pending = '0;
        if (!run_go) begin
          st.phase = bts_pkg::PH_WAIT;
        end else if (below && cfg_i.heater_enable) begin
          st.impact_is_cooler = 1'b0;
          st.phase            = bts_pkg::PH_PUMP_ON;
        end else if (above && cfg_i.cooler_enable) begin
          st.impact_is_cooler = 1'b1;
          st.phase            = bts_pkg::PH_PUMP_ON;
        end else if (has_topup) begin
          st.topup_latched = st.topup_pending[bts_pkg::AmountW-1:0];
          st.topup_pending = '0;
          st.return_phase  = bts_pkg::PH_RANGE;
          st.phase         = bts_pkg::PH_TOPUP;
        end
      end
      bts_pkg::PH_HEATING: begin
        // midpoint crossing ends the phase before the run request is looked at
        if (t2 >= mid2) begin
          st.phase = bts_pkg::PH_HEAT_OFF;
        end else begin
          st.running     = run_go;
          st.run_pending = '0;
          if (!run_go || !cfg_i.heater_enable) begin
            st.phase = bts_pkg::PH_HEAT_OFF;
          end else if (has_topup) begin
            st.topup_latched = st.topup_pending[bts_pkg::AmountW-1:0];
            st.topup_pending = '0;
            st.return_phase  = bts_pkg::PH_HEATING;
            st.phase         = bts_pkg::PH_TOPUP;
          end
        end
      end
      bts_pkg::PH_COOLING: begin
        if (t2 <= mid2) begin
          st.phase = bts_pkg::PH_COOL_OFF;
        end else begin
          st.running     = run_go;
          st.run_pending = '0;
          if (!run_go || !cfg_i.cooler_enable) begin
            st.phase = bts_pkg::PH_COOL_OFF;
          end else if (has_topup) begin
            st.topup_latched = st.topup_pending[bts_pkg::AmountW-1:0];
            st.topup_pending = '0;
            st.return_phase  = bts_pkg::PH_COOLING;
            st.phase         = bts_pkg::PH_TOPUP;
          end
        end
      end
      bts_pkg::PH_PUMP_ON: begin
        res.command_target = bts_pkg::TGT_PUMP;
        res.command_level  = 1'b1;
        if (item_i.ack_error)     st.phase = bts_pkg::PH_PUMP_ON_ERR;
        else if (item_i.ack_done) st.phase = st.impact_is_cooler ? bts_pkg::PH_COOL_ON
                                                                  : bts_pkg::PH_HEAT_ON;
      end
      bts_pkg::PH_PUMP_ON_ERR: begin
        res.fault_code = bts_pkg::FLT_PUMP_ON;
        st.phase       = bts_pkg::PH_WAIT;
      end
      bts_pkg::PH_HEAT_ON: begin
        res.command_target = bts_pkg::TGT_HEATER;
        res.command_level  = 1'b1;
        if (item_i.ack_error)     st.phase = bts_pkg::PH_HEAT_ON_ERR;
        else if (item_i.ack_done) st.phase = bts_pkg::PH_HEATING;
      end
      bts_pkg::PH_HEAT_ON_ERR: begin
        res.fault_code = bts_pkg::FLT_HEAT_ON;
        st.phase       = bts_pkg::PH_PUMP_OFF;
      end
      bts_pkg::PH_COOL_ON: begin
        res.command_target = bts_pkg::TGT_COOLER;
        res.command_level  = 1'b1;
        if (item_i.ack_error)     st.phase = bts_pkg::PH_COOL_ON_ERR;
        else if (item_i.ack_done) st.phase = bts_pkg::PH_COOLING;
      end
      bts_pkg::PH_COOL_ON_ERR: begin
        res.fault_code = bts_pkg::FLT_COOL_ON;
        st.phase       = bts_pkg::PH_PUMP_OFF;
      end
      bts_pkg::PH_PUMP_OFF: begin
        res.command_target = bts_pkg::TGT_PUMP;
        if (item_i.ack_error)     st.phase = bts_pkg::PH_PUMP_OFF_ERR;
        else if (item_i.ack_done) st.phase = bts_pkg::PH_RANGE;
      end
      bts_pkg::PH_PUMP_OFF_ERR: begin
        res.fault_code = bts_pkg::FLT_PUMP_OFF;
        st.phase       = bts_pkg::PH_RANGE;
      end
      bts_pkg::PH_HEAT_OFF: begin
        res.command_target = bts_pkg::TGT_HEATER;
        if (item_i.ack_error)     st.phase = bts_pkg::PH_HEAT_OFF_ERR;
        else if (item_i.ack_done) st.phase = bts_pkg::PH_PUMP_OFF;
      end
      bts_pkg::PH_HEAT_OFF_ERR: begin
        res.fault_code = bts_pkg::FLT_HEAT_OFF;
        st.phase       = bts_pkg::PH_RANGE;
      end
      bts_pkg::PH_COOL_OFF: begin
        res.command_target = bts_pkg::TGT_COOLER;
        if (item_i.ack_error)     st.phase = bts_pkg::PH_COOL_OFF_ERR;
        else if (item_i.ack_done) st.phase = bts_pkg::PH_PUMP_OFF;
      end
      bts_pkg::PH_COOL_OFF_ERR: begin
        res.fault_code = bts_pkg::FLT_COOL_OFF;
        st.phase       = bts_pkg::PH_RANGE;
      end
      default: begin
        st.phase = bts_pkg::PH_WAIT;
      end
    endcase

    res.phase_code = st.phase;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

>>> tb/sv/tb_barrel_thermostat_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the barrel thermostat sequencer.

class sequencer_ledger;
  // configuration copy
  logic                             heater_enable;
  logic                             cooler_enable;
  logic signed [bts_pkg::TempW-1:0] low_limit;
  logic signed [bts_pkg::TempW-1:0] high_limit;
  // predicted block state
  bts_pkg::phase_t                  phase;
  bts_pkg::phase_t                  return_phase;
  logic                             impact_is_cooler;
  logic                             running;
  logic [1:0]                       run_pending;
  logic [bts_pkg::AmountW:0]        topup_pending;
  logic [bts_pkg::AmountW-1:0]      topup_latched;
  logic signed [bts_pkg::TempW-1:0] last_temperature;

  bts_pkg::result_t                 out_now;
  bts_pkg::result_t                 expected_results[$];
  int                               mismatches;
  int                               results_checked;

  function new();
    heater_enable    = 1'b0;
    cooler_enable    = 1'b0;
    low_limit        = bts_pkg::LowLimitReset;
    high_limit       = bts_pkg::HighLimitReset;
    phase            = bts_pkg::PH_WAIT;
    return_phase     = bts_pkg::PH_WAIT;
    impact_is_cooler = 1'b0;
    running          = 1'b0;
    run_pending      = '0;
    topup_pending    = '0;
    topup_latched    = '0;
    last_temperature = '0;
    mismatches       = 0;
    results_checked  = 0;
  endfunction

  function void set_reg(bts_pkg::reg_idx_t idx, logic [bts_pkg::CfgDataW-1:0] val);
    case (idx)
      bts_pkg::REG_HEATER_ENABLE: heater_enable = val[0];
      bts_pkg::REG_COOLER_ENABLE: cooler_enable = val[0];
      bts_pkg::REG_LOW_LIMIT:     low_limit = val;
      bts_pkg::REG_HIGH_LIMIT:    high_limit = val;
      default: ;
    endcase
  endfunction

  // consumes a pending run request, returns 1 while control is stopped
  function bit stop_now();
    if (run_pending[1]) begin
      running     = run_pending[0];
      run_pending = '0;
    end
    return !running;
  endfunction

  function bit claim_topup();
    if (!topup_pending[bts_pkg::AmountW]) return 1'b0;
    topup_latched = topup_pending[bts_pkg::AmountW-1:0];
    topup_pending = '0;
    return 1'b1;
  endfunction

  function void start_topup(bts_pkg::phase_t back);
    return_phase = back;
    phase        = bts_pkg::PH_TOPUP;
  endfunction

  function void actuate(bts_pkg::target_t tg, logic lvl, logic [bts_pkg::AmountW-1:0] amt,
                        bts_pkg::item_t it, bts_pkg::phase_t ok_ph,
                        bts_pkg::phase_t err_ph);
    out_now.command_target = tg;
    out_now.command_level  = lvl;
    out_now.command_amount = amt;
    if (it.ack_error) phase = err_ph;
    else if (it.ack_done) phase = ok_ph;
  endfunction

  function bts_pkg::result_t step_phase(bts_pkg::item_t it);
    int t2;
    int mid2;
    if (it.temp_valid) last_temperature = it.temperature;
    if (it.run_request_valid) run_pending = {1'b1, it.run_request_value};
    if (it.topup_request_valid) topup_pending = {1'b1, it.topup_amount};
    // midpoint kept exact: compare 2*t against lo+hi
    t2   = 2 * int'(last_temperature);
    mid2 = int'(low_limit) + int'(high_limit);
    out_now = '0;
    out_now.command_target = bts_pkg::TGT_NONE;
    out_now.fault_code     = bts_pkg::FLT_NONE;
    case (phase)
      bts_pkg::PH_WAIT: begin
        if (!stop_now()) phase = bts_pkg::PH_RANGE;
        else if (claim_topup()) start_topup(bts_pkg::PH_WAIT);
      end
      bts_pkg::PH_TOPUP:
        actuate(bts_pkg::TGT_TOPUP, 1'b1, topup_latched, it, return_phase,
                bts_pkg::PH_TOPUP_ERR);
      bts_pkg::PH_TOPUP_ERR: begin
        out_now.fault_code = bts_pkg::FLT_TOPUP;
        phase = return_phase;
      end
      bts_pkg::PH_RANGE: begin
        if (stop_now()) begin
          phase = bts_pkg::PH_WAIT;
        end else if (last_temperature < low_limit && heater_enable) begin
          impact_is_cooler = 1'b0;
          phase = bts_pkg::PH_PUMP_ON;
        end else if (last_temperature > high_limit && cooler_enable) begin
          impact_is_cooler = 1'b1;
          phase = bts_pkg::PH_PUMP_ON;
        end else if (claim_topup()) begin
          start_topup(bts_pkg::PH_RANGE);
        end
      end
      bts_pkg::PH_HEATING: begin
        // the midpoint test goes first and then leaves a run request pending
        if (t2 >= mid2) phase = bts_pkg::PH_HEAT_OFF;
        else if (stop_now() || !heater_enable) phase = bts_pkg::PH_HEAT_OFF;
        else if (claim_topup()) start_topup(bts_pkg::PH_HEATING);
      end
      bts_pkg::PH_COOLING: begin
        if (t2 <= mid2) phase = bts_pkg::PH_COOL_OFF;
        else if (stop_now() || !cooler_enable) phase = bts_pkg::PH_COOL_OFF;
        else if (claim_topup()) start_topup(bts_pkg::PH_COOLING);
      end
      bts_pkg::PH_PUMP_ON:
        actuate(bts_pkg::TGT_PUMP, 1'b1, '0, it,
                impact_is_cooler ? bts_pkg::PH_COOL_ON : bts_pkg::PH_HEAT_ON,
                bts_pkg::PH_PUMP_ON_ERR);
      bts_pkg::PH_PUMP_ON_ERR: begin
        out_now.fault_code = bts_pkg::FLT_PUMP_ON;
        phase = bts_pkg::PH_WAIT;
      end
      bts_pkg::PH_HEAT_ON:
        actuate(bts_pkg::TGT_HEATER, 1'b1, '0, it, bts_pkg::PH_HEATING,
                bts_pkg::PH_HEAT_ON_ERR);
      bts_pkg::PH_HEAT_ON_ERR: begin
        out_now.fault_code = bts_pkg::FLT_HEAT_ON;
        phase = bts_pkg::PH_PUMP_OFF;
      end
      bts_pkg::PH_COOL_ON:
        actuate(bts_pkg::TGT_COOLER, 1'b1, '0, it, bts_pkg::PH_COOLING,
                bts_pkg::PH_COOL_ON_ERR);
      bts_pkg::PH_COOL_ON_ERR: begin
        out_now.fault_code = bts_pkg::FLT_COOL_ON;
        phase = bts_pkg::PH_PUMP_OFF;
      end
      bts_pkg::PH_PUMP_OFF:
        actuate(bts_pkg::TGT_PUMP, 1'b0, '0, it, bts_pkg::PH_RANGE,
                bts_pkg::PH_PUMP_OFF_ERR);
      bts_pkg::PH_PUMP_OFF_ERR: begin
        out_now.fault_code = bts_pkg::FLT_PUMP_OFF;
        phase = bts_pkg::PH_RANGE;
      end
      bts_pkg::PH_HEAT_OFF:
        actuate(bts_pkg::TGT_HEATER, 1'b0, '0, it, bts_pkg::PH_PUMP_OFF,
                bts_pkg::PH_HEAT_OFF_ERR);
      bts_pkg::PH_HEAT_OFF_ERR: begin
        out_now.fault_code = bts_pkg::FLT_HEAT_OFF;
        phase = bts_pkg::PH_RANGE;
      end
      bts_pkg::PH_COOL_OFF:
        actuate(bts_pkg::TGT_COOLER, 1'b0, '0, it, bts_pkg::PH_PUMP_OFF,
                bts_pkg::PH_COOL_OFF_ERR);
      bts_pkg::PH_COOL_OFF_ERR: begin
        out_now.fault_code = bts_pkg::FLT_COOL_OFF;
        phase = bts_pkg::PH_RANGE;
      end
      default: phase = bts_pkg::PH_WAIT;
    endcase
    out_now.phase_code = phase;
    return out_now;
  endfunction

  function void note_tick(bts_pkg::item_t it);
    expected_results.push_back(step_phase(it));
  endfunction

  task report(string msg);
    $display("mismatch at result %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  task check_result(bts_pkg::result_t got);
    bts_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report("result beat with nothing expected");
      results_checked++;
      return;
    end
    want = expected_results.pop_front();
    if (got.command_target !== want.command_target)
      report($sformatf("command_target %0d, expected %0d", got.command_target,
                       want.command_target));
    if (got.command_level !== want.command_level)
      report($sformatf("command_level %0d, expected %0d", got.command_level,
                       want.command_level));
    if (got.command_amount !== want.command_amount)
      report($sformatf("command_amount %0d, expected %0d", got.command_amount,
                       want.command_amount));
    if (got.phase_code !== want.phase_code)
      report($sformatf("phase_code %0d, expected %0d", got.phase_code, want.phase_code));
    if (got.fault_code !== want.fault_code)
      report($sformatf("fault_code %0d, expected %0d", got.fault_code, want.fault_code));
    results_checked++;
  endtask

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_barrel_thermostat_sequencer;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [bts_pkg::InDataW-1:0]  in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [bts_pkg::OutDataW-1:0] out_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bts_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [bts_pkg::CfgDataW-1:0] cfg_data = '0;

  sequencer_ledger ledger = new();

  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  barrel_thermostat_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check every accepted beat, then decide tready for the next cycle
  always @(posedge clk) begin
    bts_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.command_target = bts_pkg::target_t'(out_tdata[2:0]);
      got.command_level  = out_tdata[3];
      got.command_amount = out_tdata[19:4];
      got.phase_code     = bts_pkg::phase_t'(out_tdata[24:20]);
      got.fault_code     = bts_pkg::fault_t'(out_tdata[27:25]);
      ledger.check_result(got);
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_tready  <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HoldCycles;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_tick(input bts_pkg::item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, it.ack_error, it.ack_done, it.topup_amount,
                  it.topup_request_valid, it.run_request_value, it.run_request_valid,
                  it.temperature, it.temp_valid};
    do @(posedge clk); while (!in_tready);
    ledger.note_tick(it);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all four registers back to back; valid drops only after the last beat
  task automatic apply_setup(input logic heat, input logic cool,
                             input logic signed [bts_pkg::TempW-1:0] lo,
                             input logic signed [bts_pkg::TempW-1:0] hi);
    logic [bts_pkg::CfgDataW-1:0] vals[4];
    vals[bts_pkg::REG_HEATER_ENABLE] = {15'd0, heat};
    vals[bts_pkg::REG_COOLER_ENABLE] = {15'd0, cool};
    vals[bts_pkg::REG_LOW_LIMIT]     = lo;
    vals[bts_pkg::REG_HIGH_LIMIT]    = hi;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= bts_pkg::reg_idx_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      ledger.set_reg(bts_pkg::reg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // fields taken from the low bits of each argument
  function automatic bts_pkg::item_t make_tick(int tv, int temp, int rv, int rval, int tuv,
                                               int amt, int done, int err);
    bts_pkg::item_t it;
    it.temp_valid          = tv[0];
    it.temperature         = temp[bts_pkg::TempW-1:0];
    it.run_request_valid   = rv[0];
    it.run_request_value   = rval[0];
    it.topup_request_valid = tuv[0];
    it.topup_amount        = amt[bts_pkg::AmountW-1:0];
    it.ack_done            = done[0];
    it.ack_error           = err[0];
    return it;
  endfunction

  // random tick steered by the predicted phase so that the sequences get deep
  function automatic bts_pkg::item_t random_tick();
    bts_pkg::item_t it;
    int    lo;
    int    hi;
    int    t;
    int    r;
    bit    commanding;
    lo = ledger.low_limit;
    hi = ledger.high_limit;
    it = '0;
    it.temp_valid = ($urandom_range(0, 99) < 45);
    case ($urandom_range(0, 9))
      0, 1, 2: t = lo - int'($urandom_range(1, 160));
      3, 4, 5: t = hi + int'($urandom_range(1, 160));
      6, 7:    t = (lo + hi) / 2 + int'($urandom_range(0, 8)) - 4;
      8:       t = int'($urandom_range(0, 65535)) - 32768;
      default: t = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    it.temperature         = t[bts_pkg::TempW-1:0];
    it.run_request_valid   = ($urandom_range(0, 99) < 6);
    it.run_request_value   = ($urandom_range(0, 99) < 75);
    it.topup_request_valid = ($urandom_range(0, 99) < 5);
    case ($urandom_range(0, 7))
      0:       it.topup_amount = '0;
      1:       it.topup_amount = '1;
      default: it.topup_amount = 16'($urandom_range(0, 65535));
    endcase
    commanding = ledger.phase inside {bts_pkg::PH_TOPUP, bts_pkg::PH_PUMP_ON,
                                      bts_pkg::PH_HEAT_ON, bts_pkg::PH_COOL_ON,
                                      bts_pkg::PH_PUMP_OFF, bts_pkg::PH_HEAT_OFF,
                                      bts_pkg::PH_COOL_OFF};
    if (commanding) begin
      r = $urandom_range(0, 99);
      it.ack_error = (r >= 60 && r < 72);
      it.ack_done  = (r < 60) || (it.ack_error && $urandom_range(0, 1));
    end else begin
      it.ack_done  = ($urandom_range(0, 99) < 30);
      it.ack_error = ($urandom_range(0, 99) < 15);
    end
    return it;
  endfunction

  task automatic run_random(input int count, input int pause_every);
    for (int k = 0; k < count; k++) begin
      send_tick(random_tick());
      if (pause_every != 0 && k % pause_every == pause_every - 1) drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_setup(1'b1, 1'b1, 16'sd320, 16'sd1280);
    // top-up of zero litres, repeat, error beats done, answer ignored in error phase
    send_tick(make_tick(0, 0, 0, 0, 1, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 1));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    // start cold: pump, heater fails, pump off
    send_tick(make_tick(1, -32768, 1, 1, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 1));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    // heat properly, top-up while heating, exit at the exact midpoint with a stop queued
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    send_tick(make_tick(0, 0, 0, 0, 1, 16'hFFFF, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    send_tick(make_tick(1, 800, 1, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 1));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    // restart hot: cooling path, cooler close fails
    send_tick(make_tick(1, 32767, 1, 1, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 1, 0));
    send_tick(make_tick(1, 800, 0, 0, 0, 16'd0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 1));
    send_tick(make_tick(0, 0, 0, 0, 0, 16'd0, 0, 0));
    drain();

    // no idling, one long receiver hold-off so the input side backs up
    apply_setup(1'b1, 1'b1, 16'sd320, 16'sd1280);
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_requests = hold_requests + 1;
    run_random(125, 0);
    drain();

    // widest limits, heater only
    apply_setup(1'b1, 1'b0, 16'sh8000, 16'sd32767);
    send_idle_pct = 73;
    rx_stall_pct  = 0;
    run_random(125, 0);
    drain();

    apply_setup(1'b0, 1'b1, -16'sd100, 16'sd200);
    send_idle_pct = 0;
    rx_stall_pct  = 73;
    run_random(125, 0);
    drain();

    // inverted limits
    apply_setup(1'b1, 1'b1, 16'sd1000, -16'sd1000);
    send_idle_pct = 27;
    rx_stall_pct  = 27;
    run_random(125, 0);
    drain();

    apply_setup(1'b1, 1'b1, 16'sd32767, 16'sh8000);
    send_idle_pct = 73;
    rx_stall_pct  = 0;
    run_random(125, 0);
    drain();

    // random sane window, sender pauses until the block is empty now and then
    begin
      logic signed [bts_pkg::TempW-1:0] lo_pick;
      lo_pick = 16'($urandom_range(0, 2000)) - 16'd1000;
      apply_setup(1'b1, 1'b1, lo_pick, lo_pick + 16'($urandom_range(16, 2000)));
    end
    send_idle_pct = 27;
    rx_stall_pct  = 27;
    run_random(125, 40);
    drain();

    if (ledger.mismatches == 0 && ledger.pending() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
